// ===== hw/rtl/lfpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lfpd_pkg;

    // Geometry of the sensor bar and of the shared divider
    localparam int SENSOR_COUNT = 8;
    localparam int DIV_W        = 21;   // |(error change) * 1000| < 2^21
    localparam int DVSR_W       = 32;   // elapsed milliseconds
    localparam int DIV_CNT_W    = $clog2(DIV_W);

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LEFT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_RIGHT = 3'd4;

    // Reset values of the configuration registers
    localparam logic [15:0] PROP_GAIN_RST    = 16'd8960;  // 35.0 in Q8.8
    localparam logic [15:0] DERIV_GAIN_RST   = 16'd256;   // 1.0 in Q8.8
    localparam logic [7:0]  BASE_SPEED_RST   = 8'd80;
    localparam logic [7:0]  SEARCH_LEFT_RST  = 8'd0;
    localparam logic [7:0]  SEARCH_RIGHT_RST = 8'd100;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] deriv_gain;
        logic [7:0]  base_speed;
        logic [7:0]  search_left;
        logic [7:0]  search_right;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_ERR,
        ST_DIV_ERR,
        ST_LOAD_DER,
        ST_DIV_DER,
        ST_MUL_P,
        ST_MUL_D,
        ST_SUM,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic err_start;
        logic err_take;
        logic der_start;
        logic der_clear;
        logic der_take;
        logic mul_p;
        logic mul_d;
        logic sum;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_lost;
        logic dt_zero;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/line_follow_pd_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none

// PD line-follower controller.
// Input stream (s_*): one item per control update, carrying the eight sensor
// bits and a millisecond timestamp. Result stream (m_*): one item per input,
// carrying left and right PWM duty and a line-lost flag in tuser.
// Configuration channel (cfg_*): index 0 prop gain, 1 deriv gain, 2 base
// speed, 3 search left, 4 search right; other indexes are ignored. Always
// ready; write only while no item is in flight.
// Flow: one shared restoring divider is used once for the line error and
// once for the derivative. An item with the line in view passes through
// both divides, two products and the sum; when no time has elapsed since the
// last update the derivative divide is skipped and the derivative is zero;
// when no sensor sees the line the item goes straight to the output step.
// One item is worked at a time. The result sits in an output register, so a
// stalled receiver holds only that register: the next item is accepted and
// worked, and it waits in the final step until the register frees up.
// Reset (aresetn low at a clock edge) restores the register defaults, clears
// the error and time history to zero and drops any pending result.
module line_follow_pd_controller (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,    // [7:0] sensor_bits, [39:8] time_ms
    // Result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,    // [7:0] left_pwm, [15:8] right_pwm
    output logic [0:0]       m_tuser,    // [0] line_lost
    // Register writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    lfpd_pkg::cfg_t    cfg_reg;
    lfpd_pkg::cmd_t    cmd;
    lfpd_pkg::status_t status;

    // Register file: take a write every cycle, drop unknown indexes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain    <= lfpd_pkg::PROP_GAIN_RST;
            cfg_reg.deriv_gain   <= lfpd_pkg::DERIV_GAIN_RST;
            cfg_reg.base_speed   <= lfpd_pkg::BASE_SPEED_RST;
            cfg_reg.search_left  <= lfpd_pkg::SEARCH_LEFT_RST;
            cfg_reg.search_right <= lfpd_pkg::SEARCH_RIGHT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                lfpd_pkg::REG_PROP_GAIN:    cfg_reg.prop_gain    <= cfg_data;
                lfpd_pkg::REG_DERIV_GAIN:   cfg_reg.deriv_gain   <= cfg_data;
                lfpd_pkg::REG_BASE_SPEED:   cfg_reg.base_speed   <= cfg_data[7:0];
                lfpd_pkg::REG_SEARCH_LEFT:  cfg_reg.search_left  <= cfg_data[7:0];
                lfpd_pkg::REG_SEARCH_RIGHT: cfg_reg.search_right <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Capture, one or two divides, two products, sum; lost items skip these
    lfpd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Error, derivative, correction and the output register
    lfpd_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // In the cycle after an item is taken, the block is not ready for input
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> !s_tready)
        else $error("input ready right after an accept");

    // The divider only finishes while an item is being worked
    a_div_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> !s_tready)
        else $error("divider finished while idle");

    // Loading a result always presents it on the next cycle
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_tvalid)
        else $error("result loaded but not presented");

    // A lost-line item never starts a divide
    a_lost_no_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.capture && status.in_lost) |=> !cmd.err_start)
        else $error("divide started for a lost-line item");

endmodule

`default_nettype wire

// ===== hw/rtl/lfpd_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lfpd_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [lfpd_pkg::DIV_W-1:0]  dividend,
    input  wire logic [lfpd_pkg::DVSR_W-1:0] divisor,
    output logic                            done,
    output logic [lfpd_pkg::DIV_W-1:0]       quotient
);

    localparam int DW = lfpd_pkg::DIV_W;
    localparam int VW = lfpd_pkg::DVSR_W;
    localparam int CW = lfpd_pkg::DIV_CNT_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] dvsr_reg, dvsr_next;

    logic [VW:0]   rem_shift;
    logic [VW:0]   rem_diff;

    // Restoring division, one quotient bit a cycle, MSB first
    always_comb begin
        rem_shift = {rem_reg, quo_reg[DW-1]};
        rem_diff  = rem_shift - {1'b0, dvsr_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvsr_next = dvsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvsr_next = divisor;
        end else if (busy_reg) begin
            if (rem_shift >= {1'b0, dvsr_reg}) begin
                rem_next = rem_diff[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvsr_reg <= dvsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lfpd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lfpd_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire lfpd_pkg::status_t status,
    output lfpd_pkg::cmd_t         cmd
);

    lfpd_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lfpd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lfpd_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = status.in_lost ? lfpd_pkg::ST_DONE : lfpd_pkg::ST_LOAD_ERR;
                end
            end
            lfpd_pkg::ST_LOAD_ERR: begin
                state_next = lfpd_pkg::ST_DIV_ERR;
            end
            lfpd_pkg::ST_DIV_ERR: begin
                if (status.div_done) begin
                    state_next = lfpd_pkg::ST_LOAD_DER;
                end
            end
            lfpd_pkg::ST_LOAD_DER: begin
                state_next = status.dt_zero ? lfpd_pkg::ST_MUL_P : lfpd_pkg::ST_DIV_DER;
            end
            lfpd_pkg::ST_DIV_DER: begin
                if (status.div_done) begin
                    state_next = lfpd_pkg::ST_MUL_P;
                end
            end
            lfpd_pkg::ST_MUL_P: begin
                state_next = lfpd_pkg::ST_MUL_D;
            end
            lfpd_pkg::ST_MUL_D: begin
                state_next = lfpd_pkg::ST_SUM;
            end
            lfpd_pkg::ST_SUM: begin
                state_next = lfpd_pkg::ST_DONE;
            end
            lfpd_pkg::ST_DONE: begin
                if (status.out_free) begin
                    state_next = lfpd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lfpd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            lfpd_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            lfpd_pkg::ST_LOAD_ERR: begin
                cmd.err_start = 1'b1;
            end
            lfpd_pkg::ST_DIV_ERR: begin
                cmd.err_take = status.div_done;
            end
            lfpd_pkg::ST_LOAD_DER: begin
                cmd.der_start = !status.dt_zero;
                cmd.der_clear = status.dt_zero;
            end
            lfpd_pkg::ST_DIV_DER: begin
                cmd.der_take = status.div_done;
            end
            lfpd_pkg::ST_MUL_P: begin
                cmd.mul_p = 1'b1;
            end
            lfpd_pkg::ST_MUL_D: begin
                cmd.mul_d = 1'b1;
            end
            lfpd_pkg::ST_SUM: begin
                cmd.sum = 1'b1;
            end
            lfpd_pkg::ST_DONE: begin
                cmd.load_out = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lfpd_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lfpd_dp (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire lfpd_pkg::cfg_t cfg,
    input  wire lfpd_pkg::cmd_t cmd,
    output lfpd_pkg::status_t   status,
    input  wire logic [39:0]    s_tdata,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [15:0]         m_tdata,
    output logic [0:0]          m_tuser
);

    localparam int DW = lfpd_pkg::DIV_W;
    localparam int NS = lfpd_pkg::SENSOR_COUNT;

    localparam logic signed [3:0] WEIGHT [NS] = '{-4'sd3, -4'sd2, -4'sd1, 4'sd0,
                                                  4'sd0, 4'sd1, 4'sd2, 4'sd3};

    // Q.16 value to an integer duty, clamped to 0..255
    function automatic logic [7:0] to_duty(input logic signed [41:0] q);
        logic [7:0] duty;
        if (q <= 42'sd0) begin
            duty = 8'd0;
        end else if (q[41:24] != 18'd0) begin
            duty = 8'd255;
        end else begin
            duty = q[23:16];
        end
        return duty;
    endfunction

    // Item capture
    logic signed [3:0]  wsum_in;
    logic [3:0]         cnt_in;
    logic signed [3:0]  wsum_reg;
    logic [3:0]         cnt_reg;
    logic [31:0]        time_reg;
    logic               lost_reg;

    // Controller state
    logic signed [11:0] err_reg, err_next;
    logic signed [11:0] last_err_reg;
    logic [31:0]        last_time_reg;
    logic signed [21:0] deriv_reg, deriv_next;
    logic signed [39:0] prod_reg;
    logic signed [40:0] corr_reg;
    logic               neg_reg;

    // Output stage
    logic               out_valid_reg;
    logic [7:0]         left_reg, right_reg;
    logic               out_lost_reg;

    // Divider connection
    logic               div_start;
    logic [DW-1:0]      div_dividend;
    logic [31:0]        div_divisor;
    logic               div_done;
    logic [DW-1:0]      div_quotient;

    logic [3:0]         wabs;
    logic signed [12:0] diff;
    logic signed [22:0] scaled;
    logic [22:0]        scaled_abs;
    logic [31:0]        dt;

    logic signed [16:0] mul_a;
    logic signed [22:0] mul_b;
    logic signed [39:0] mul_prod;

    logic signed [41:0] base_q;
    logic signed [41:0] left_q, right_q;

    always_comb begin
        wsum_in = 4'sd0;
        cnt_in  = 4'd0;
        for (int i = 0; i < NS; i++) begin
            if (s_tdata[i]) begin
                wsum_in = wsum_in + WEIGHT[i];
                cnt_in  = cnt_in + 4'd1;
            end
        end
    end

    always_comb begin
        wabs       = wsum_reg[3] ? -wsum_reg : wsum_reg;
        diff       = {err_reg[11], err_reg} - {last_err_reg[11], last_err_reg};
        scaled     = 23'(diff) * 23'sd1000;
        scaled_abs = scaled[22] ? 23'(-scaled) : 23'(scaled);
        dt         = time_reg - last_time_reg;
    end

    always_comb begin
        div_start = cmd.err_start | cmd.der_start;
        if (cmd.der_start) begin
            div_dividend = scaled_abs[DW-1:0];
            div_divisor  = dt;
        end else begin
            div_dividend = DW'({wabs, 8'd0});
            div_divisor  = {28'd0, cnt_reg};
        end
    end

    lfpd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        err_next   = neg_reg ? -12'(div_quotient) : 12'(div_quotient);
        deriv_next = neg_reg ? -22'(div_quotient) : 22'(div_quotient);
    end

    // Shared multiplier, gain times error or derivative
    always_comb begin
        mul_a    = cmd.mul_d ? {1'b0, cfg.deriv_gain} : {1'b0, cfg.prop_gain};
        mul_b    = cmd.mul_d ? 23'(deriv_reg) : 23'(err_reg);
        mul_prod = 40'(mul_a) * 40'(mul_b);
    end

    always_comb begin
        base_q  = {18'd0, cfg.base_speed, 16'd0};
        left_q  = base_q - 42'(corr_reg);
        right_q = base_q + 42'(corr_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            wsum_reg <= wsum_in;
            cnt_reg  <= cnt_in;
            time_reg <= s_tdata[39:8];
            lost_reg <= (cnt_in == 4'd0);
        end
        if (cmd.err_start) begin
            neg_reg <= wsum_reg[3];
        end else if (cmd.der_start) begin
            neg_reg <= scaled[22];
        end
        if (cmd.err_take) begin
            err_reg <= err_next;
        end
        if (cmd.der_clear) begin
            deriv_reg <= '0;
        end else if (cmd.der_take) begin
            deriv_reg <= deriv_next;
        end
        if (cmd.mul_p || cmd.mul_d) begin
            prod_reg <= mul_prod;
        end
        if (cmd.mul_d) begin
            corr_reg <= 41'(prod_reg);
        end else if (cmd.sum) begin
            corr_reg <= corr_reg + 41'(prod_reg);
        end
        if (cmd.load_out) begin
            if (lost_reg) begin
                left_reg     <= cfg.search_left;
                right_reg    <= cfg.search_right;
                out_lost_reg <= 1'b1;
            end else begin
                left_reg     <= to_duty(left_q);
                right_reg    <= to_duty(right_q);
                out_lost_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg  <= '0;
            last_time_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load_out && !lost_reg) begin
                last_err_reg  <= err_reg;
                last_time_reg <= time_reg;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        status.in_lost  = (s_tdata[NS-1:0] == '0);
        status.dt_zero  = (dt == 32'd0);
        status.div_done = div_done;
        status.out_free = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {right_reg, left_reg};
    assign m_tuser  = out_lost_reg;

endmodule

`default_nettype wire
